FILE: src/callback_label_match_table_macros.svh
// ----------------------------------------------------------------------------
// callback_label_match_table_macros
// Assertion macros for the callback label match table.
// Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CALLBACK_LABEL_MATCH_TABLE_MACROS_SVH
`define CALLBACK_LABEL_MATCH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define CBLMT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CBLMT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBLMT_ASSERT(name, clk, rst_n, prop, msg)
`define CBLMT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: src/cblmt_pkg.sv
// ----------------------------------------------------------------------------
// cblmt_pkg
// Shared constants, operation codes and control structs for the callback
// label match table.
// ----------------------------------------------------------------------------
package cblmt_pkg;

    localparam int DEPTH    = 16;                 // table slots, at most 0xFE
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W   = 32;                 // label, task and argument width
    localparam int KIND_W   = 3;
    localparam int RKIND_W  = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_REGISTER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_LABEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_TASK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRE_ERR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RELABEL   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

    // result kinds
    localparam logic [RKIND_W-1:0] RES_STATUS   = 2'd0;
    localparam logic [RKIND_W-1:0] RES_DISPATCH = 2'd1;
    localparam logic [RKIND_W-1:0] RES_DONE     = 2'd2;

    // status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // register indexes
    localparam logic REG_FRONT_QUEUE = 1'b0;

    typedef struct packed {
        logic ld_op;
        logic exec;
        logic emit_stat;
        logic emit_disp;
        logic emit_done;
    } cblmt_cmd_t;

    typedef struct packed {
        logic is_fire;
        logic pend_any;
        logic out_free;
    } cblmt_sts_t;

endpackage

FILE: src/cblmt_ctrl.sv
// ----------------------------------------------------------------------------
// cblmt_ctrl
// Sequencer: takes one operation, runs it on the table, then issues the
// status word or walks the pending dispatches and closes with done.
// ----------------------------------------------------------------------------
module cblmt_ctrl import cblmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cblmt_sts_t sts,
    output cblmt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_STAT = 2'd2;
    localparam logic [1:0] ST_DISP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_op  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_fire ? ST_DISP : ST_STAT;
            end
            ST_STAT: begin
                if (sts.out_free) begin
                    cmd.emit_stat = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DISP: begin
                if (sts.out_free) begin
                    if (sts.pend_any) begin
                        cmd.emit_disp = 1'b1;
                    end else begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`include "callback_label_match_table_macros.svh"

    `CBLMT_ASSERT(a_one_emit, aclk, aresetn, $onehot0({cmd.emit_stat, cmd.emit_disp, cmd.emit_done}), "more than one result issued in a cycle")
    `CBLMT_ASSERT(a_emit_needs_room, aclk, aresetn, (cmd.emit_stat || cmd.emit_disp || cmd.emit_done) |-> sts.out_free, "result issued into a full output register")
    `CBLMT_ASSERT(a_done_to_idle, aclk, aresetn, (cmd.emit_done || cmd.emit_stat) |=> s_ready, "not ready after the last word of a run")
    `CBLMT_ASSERT(a_exec_after_load, aclk, aresetn, cmd.ld_op |=> cmd.exec, "operation loaded but not executed")

endmodule

FILE: src/cblmt_dpath.sv
// ----------------------------------------------------------------------------
// cblmt_dpath
// Table storage, operation register, match logic, pending dispatch mask and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module cblmt_dpath import cblmt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cblmt_cmd_t          cmd,
    output cblmt_sts_t          sts,
    input  logic                front_queue,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [WORD_W-1:0]   s_label,
    input  logic [WORD_W-1:0]   s_task_handle,
    input  logic [WORD_W-1:0]   s_first_arg,
    input  logic [WORD_W-1:0]   s_pointer_arg,
    input  logic [WORD_W-1:0]   s_new_label,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RKIND_W-1:0]  m_result_kind,
    output logic                m_status,
    output logic [WORD_W-1:0]   m_out_task,
    output logic [WORD_W-1:0]   m_out_first_arg,
    output logic [WORD_W-1:0]   m_out_pointer_arg,
    output logic                m_to_front,
    output logic                m_last
);

    // operation held for the whole run
    logic [KIND_W-1:0] op_kind_reg;
    logic [WORD_W-1:0] op_label_reg;
    logic [WORD_W-1:0] op_task_reg;
    logic [WORD_W-1:0] op_arg_reg;
    logic [WORD_W-1:0] op_ptr_reg;
    logic [WORD_W-1:0] op_nlab_reg;

    logic [WORD_W-1:0] label_reg [DEPTH];
    logic [WORD_W-1:0] task_reg  [DEPTH];
    logic [WORD_W-1:0] cnt_reg   [DEPTH];
    logic [WORD_W-1:0] ptr_reg   [DEPTH];

    logic [DEPTH-1:0]  pend_reg;
    logic              status_reg;

    logic              m_valid_reg;
    logic [RKIND_W-1:0] m_kind_reg;
    logic              m_status_reg;
    logic [WORD_W-1:0] m_task_reg;
    logic [WORD_W-1:0] m_arg_reg;
    logic [WORD_W-1:0] m_ptr_reg;
    logic              m_front_reg;
    logic              m_last_reg;

    logic              lab_nz;
    logic [DEPTH-1:0]  match;
    logic [DEPTH-1:0]  free;
    logic [DEPTH-1:0]  task_hit;
    logic [DEPTH-1:0]  task_nz;
    logic [IDX_W-1:0]  free_idx;
    logic              free_any;
    logic [IDX_W-1:0]  disp_idx;
    logic              is_fire;
    logic              out_free;

    assign lab_nz   = (op_label_reg != '0);
    assign is_fire  = (op_kind_reg == KIND_FIRE) || (op_kind_reg == KIND_FIRE_ERR);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i]    = lab_nz && (label_reg[i] == op_label_reg);
            free[i]     = (label_reg[i] == '0);
            task_hit[i] = !free[i] && (task_reg[i] == op_task_reg);
            task_nz[i]  = (task_reg[i] != '0);
        end
    end

    // lowest free slot and lowest pending dispatch
    always_comb begin
        free_idx = '0;
        disp_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (free[i]) begin
                free_idx = IDX_W'(i);
            end
            if (pend_reg[i]) begin
                disp_idx = IDX_W'(i);
            end
        end
    end
    assign free_any = |free;

    assign sts.is_fire  = is_fire;
    assign sts.pend_any = |pend_reg;
    assign sts.out_free = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.ld_op) begin
            op_kind_reg  <= s_kind;
            op_label_reg <= s_label;
            op_task_reg  <= s_task_handle;
            op_arg_reg   <= s_first_arg;
            op_ptr_reg   <= s_pointer_arg;
            op_nlab_reg  <= s_new_label;
        end
    end

    // labels: cleared by reset, every slot free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                label_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            case (op_kind_reg)
                KIND_REGISTER: begin
                    if (lab_nz && free_any) begin
                        label_reg[free_idx] <= op_label_reg;
                    end
                end
                KIND_DEL_LABEL, KIND_FIRE, KIND_FIRE_ERR: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (match[i]) begin
                            label_reg[i] <= '0;
                        end
                    end
                end
                KIND_DEL_TASK: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (task_hit[i]) begin
                            label_reg[i] <= '0;
                        end
                    end
                end
                KIND_RELABEL: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (match[i]) begin
                            label_reg[i] <= op_nlab_reg;
                        end
                    end
                end
                KIND_CLEAR: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        label_reg[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && (op_kind_reg == KIND_REGISTER) && lab_nz && free_any) begin
            task_reg[free_idx] <= op_task_reg;
            cnt_reg[free_idx]  <= op_arg_reg;
            ptr_reg[free_idx]  <= op_ptr_reg;
        end
    end

    // matches with a zero task are freed but never queued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            status_reg <= STAT_OK;
        end else begin
            if (cmd.exec) begin
                pend_reg   <= is_fire ? (match & task_nz) : '0;
                status_reg <= ((op_kind_reg == KIND_REGISTER) && lab_nz && !free_any)
                              ? STAT_FULL : STAT_OK;
            end else if (cmd.emit_disp) begin
                pend_reg[disp_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_stat || cmd.emit_disp || cmd.emit_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_disp) begin
            m_kind_reg   <= RES_DISPATCH;
            m_status_reg <= STAT_OK;
            m_task_reg   <= task_reg[disp_idx];
            m_arg_reg    <= (op_kind_reg == KIND_FIRE_ERR) ? op_arg_reg : cnt_reg[disp_idx];
            m_ptr_reg    <= ptr_reg[disp_idx];
            m_front_reg  <= (op_kind_reg == KIND_FIRE) ? front_queue : 1'b0;
            m_last_reg   <= 1'b0;
        end else if (cmd.emit_stat || cmd.emit_done) begin
            m_kind_reg   <= cmd.emit_done ? RES_DONE : RES_STATUS;
            m_status_reg <= cmd.emit_done ? STAT_OK : status_reg;
            m_task_reg   <= '0;
            m_arg_reg    <= '0;
            m_ptr_reg    <= '0;
            m_front_reg  <= 1'b0;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_kind     = m_kind_reg;
    assign m_status          = m_status_reg;
    assign m_out_task        = m_task_reg;
    assign m_out_first_arg   = m_arg_reg;
    assign m_out_pointer_arg = m_ptr_reg;
    assign m_to_front        = m_front_reg;
    assign m_last            = m_last_reg;

`include "callback_label_match_table_macros.svh"

    `CBLMT_ASSERT_ALWAYS(a_out_idle_after_reset, aclk, !aresetn |=> !m_valid_reg, "output word valid after reset")
    `CBLMT_ASSERT(a_disp_task_nz, aclk, aresetn, (m_valid_reg && (m_kind_reg == RES_DISPATCH)) |-> (m_task_reg != '0), "dispatch of a zero task")
    `CBLMT_ASSERT(a_disp_not_last, aclk, aresetn, (m_valid_reg && (m_kind_reg == RES_DISPATCH)) |-> !m_last_reg, "dispatch word marked last")
    `CBLMT_ASSERT(a_pend_shrinks, aclk, aresetn, cmd.emit_disp |=> ($countones(pend_reg) == $countones($past(pend_reg)) - 1), "pending mask did not lose one bit")

endmodule

FILE: src/callback_label_match_table.sv
// ----------------------------------------------------------------------------
// callback_label_match_table
// Label match table of callback entries with register, delete, fire,
// relabel and clear operations, and an APB control register.
//
//   channel   direction  ports        word
//   s_        in         s_valid/rdy  one operation
//   m_        out        m_valid/rdy  status, dispatch or done
//   apb       in         psel..pready front_queue register
//
// An operation is executed in the cycle after it is taken; a non-fire
// operation then gives its status word, and a new word is taken only
// once that status word has been issued.
// A fire gives one dispatch word a cycle while the output register is
// free, then done; a single output register holds each word.
// Reset frees every slot at once; no clearing pass is needed.
// A stalled output holds the sequencer in place; nothing is taken meanwhile.
// ----------------------------------------------------------------------------
module callback_label_match_table import cblmt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [WORD_W-1:0]   s_label,
    input  logic [WORD_W-1:0]   s_task_handle,
    input  logic [WORD_W-1:0]   s_first_arg,
    input  logic [WORD_W-1:0]   s_pointer_arg,
    input  logic [WORD_W-1:0]   s_new_label,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RKIND_W-1:0]  m_result_kind,
    output logic                m_status,
    output logic [WORD_W-1:0]   m_out_task,
    output logic [WORD_W-1:0]   m_out_first_arg,
    output logic [WORD_W-1:0]   m_out_pointer_arg,
    output logic                m_to_front,
    output logic                m_last
);

    logic       front_queue_reg;
    logic       reg_sel;
    cblmt_cmd_t cmd;
    cblmt_sts_t sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_queue_reg <= 1'b0;
        end else if (psel && penable && pwrite && (reg_sel == REG_FRONT_QUEUE)) begin
            front_queue_reg <= pwdata[0];
        end
    end

    assign prdata = (reg_sel == REG_FRONT_QUEUE) ? {{(APB_DW-1){1'b0}}, front_queue_reg} : '0;

    cblmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cblmt_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .front_queue       (front_queue_reg),
        .s_kind            (s_kind),
        .s_label           (s_label),
        .s_task_handle     (s_task_handle),
        .s_first_arg       (s_first_arg),
        .s_pointer_arg     (s_pointer_arg),
        .s_new_label       (s_new_label),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_status          (m_status),
        .m_out_task        (m_out_task),
        .m_out_first_arg   (m_out_first_arg),
        .m_out_pointer_arg (m_out_pointer_arg),
        .m_to_front        (m_to_front),
        .m_last            (m_last)
    );

endmodule
